>>> hw/rtl/ebt_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and defaults for the expiring block table
// no dependencies

package ebt_pkg;

  localparam int NUM_SETS_DEF = 64;
  localparam int WAYS_DEF     = 4;

  localparam int ACTION_W = 2;
  localparam int KEY_W    = 32;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 2;

  localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SET    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SET_FULL  = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  typedef struct packed {
    logic                wr_en;
    logic                blocked;
    logic [STATUS_W-1:0] status;
  } upd_ctl_t;

  // index width that also covers a depth of one
  function automatic int idx_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

>>> hw/rtl/ebt_in_if.sv
`timescale 1ns / 1ps
// request channel: valid/ready plus one request word
// depends on ebt_pkg

interface ebt_in_if import ebt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [KEY_W-1:0]    key;
  logic [TIME_W-1:0]   duration_ms;

  modport source (output valid, output action, output key, output duration_ms, input ready);
  modport sink (input valid, input action, input key, input duration_ms, output ready);
endinterface

>>> hw/rtl/ebt_out_if.sv
`timescale 1ns / 1ps
// result channel: valid/ready plus one result word
// depends on ebt_pkg

interface ebt_out_if import ebt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                blocked;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output blocked, output status, input ready);
  modport sink (input valid, input blocked, input status, output ready);
endinterface

>>> hw/rtl/ebt_set_index.sv
`timescale 1ns / 1ps
// set index stage: key mod NUM_SETS by reciprocal multiply, one correction step
// depends on ebt_pkg

module ebt_set_index import ebt_pkg::*; #(
  parameter int NUM_SETS = NUM_SETS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [KEY_W-1:0]             key_i,
  output logic [KEY_W-1:0]             key_o,
  output logic [idx_w(NUM_SETS)-1:0]   idx_o
);

  localparam int SET_W = idx_w(NUM_SETS);
  localparam int SHIFT = $clog2(NUM_SETS) + KEY_W;
  localparam int PROD_W = 2 * KEY_W + 1;
  localparam logic [63:0] RECIP64 = (64'd1 << SHIFT) / 64'(NUM_SETS);
  localparam logic [KEY_W:0] RECIP = RECIP64[KEY_W:0];
  localparam logic [KEY_W-1:0] NSETS = KEY_W'(NUM_SETS);

  logic [PROD_W-1:0] prod;
  logic [KEY_W-1:0]  q_nxt;
  logic [KEY_W-1:0]  q_r;
  logic [KEY_W-1:0]  key_r;
  logic [KEY_W-1:0]  rem;
  logic [KEY_W-1:0]  rem_fix;

  // quotient estimate is exact or one low
  assign prod  = PROD_W'(key_i) * PROD_W'(RECIP);
  assign q_nxt = KEY_W'(prod >> SHIFT);

  always_ff @(posedge clk) begin
    if (en) begin
      key_r <= key_i;
      q_r   <= q_nxt;
    end
  end

  assign rem     = key_r - q_r * NSETS;
  assign rem_fix = (rem >= NSETS) ? rem - NSETS : rem;
  assign idx_o   = rem_fix[SET_W-1:0];
  assign key_o   = key_r;

endmodule

>>> hw/rtl/ebt_way_update.sv
`timescale 1ns / 1ps
// way compare and row update for one request against one set
// depends on ebt_pkg

module ebt_way_update import ebt_pkg::*; #(
  parameter int WAYS = WAYS_DEF
) (
  input  logic [ACTION_W-1:0]  action_i,
  input  logic [KEY_W-1:0]     key_i,
  input  logic [TIME_W-1:0]    dur_i,
  input  logic [TIME_W-1:0]    now_i,
  input  entry_t [WAYS-1:0]    row_i,
  output entry_t [WAYS-1:0]    row_o,
  output upd_ctl_t             ctl_o
);

  localparam int WAY_W = idx_w(WAYS);

  logic [WAYS-1:0]   hit;
  logic [WAYS-1:0]   free;
  logic [WAY_W-1:0]  hit_idx;
  logic [WAY_W-1:0]  free_idx;
  logic [TIME_W-1:0] expiry_new;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit[w]  = row_i[w].valid && (row_i[w].key == key_i);
      free[w] = !row_i[w].valid;
    end
    // lowest way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit[w]) hit_idx = WAY_W'(w);
      if (free[w]) free_idx = WAY_W'(w);
    end
  end

  assign expiry_new = dur_i + now_i;

  always_comb begin
    row_o          = row_i;
    ctl_o.wr_en    = 1'b0;
    ctl_o.blocked  = 1'b0;
    ctl_o.status   = ST_OK;
    case (action_i)
      ACT_TICK: begin
      end
      ACT_SET: begin
        if (|hit) begin
          ctl_o.wr_en    = 1'b1;
          row_o[hit_idx] = '{valid: 1'b1, key: key_i, expiry: expiry_new};
        end else if (|free) begin
          ctl_o.wr_en     = 1'b1;
          row_o[free_idx] = '{valid: 1'b1, key: key_i, expiry: expiry_new};
        end else begin
          ctl_o.status = ST_SET_FULL;
        end
      end
      ACT_REMOVE: begin
        if (|hit) begin
          ctl_o.wr_en          = 1'b1;
          row_o[hit_idx].valid = 1'b0;
        end else begin
          ctl_o.status = ST_NOT_FOUND;
        end
      end
      ACT_QUERY: begin
        if (|hit) begin
          if (now_i < row_i[hit_idx].expiry) begin
            ctl_o.blocked = 1'b1;
          end else begin
            ctl_o.wr_en          = 1'b1;
            row_o[hit_idx].valid = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hw/rtl/expiring_block_table.sv
`timescale 1ns / 1ps
// a word passes the index, set read and update stages before result valid
// throughput: one word per cycle unless out_ch stalls or clearing runs; the row read
// ahead of its write-back, bypassing the row written in the same cycle, sets that rate
// reset: synchronous; then a clearing pass over the NUM_SETS sets (64 by default) of
// the set memory with in_ch.ready low; now_r restarts at zero
// depends on ebt_pkg, ebt_in_if, ebt_out_if, ebt_set_index, ebt_way_update

module expiring_block_table import ebt_pkg::*; #(
  parameter int NUM_SETS = NUM_SETS_DEF,
  parameter int WAYS     = WAYS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ebt_in_if.sink     in_ch,
  ebt_out_if.source  out_ch
);

  localparam int SET_W = idx_w(NUM_SETS);
  localparam logic [SET_W-1:0] CLR_LAST = SET_W'(NUM_SETS - 1);

  typedef entry_t [WAYS-1:0] row_t;

  logic                clr_busy_r;
  logic [SET_W-1:0]    clr_idx_r;
  logic                v1_r, v2_r, v3_r;
  logic [ACTION_W-1:0] act1_r, act2_r, act3_r;
  logic [KEY_W-1:0]    key1_r, key3_r;
  logic [TIME_W-1:0]   dur1_r, dur2_r, dur3_r;
  logic [SET_W-1:0]    idx3_r;
  logic [TIME_W-1:0]   now_r;
  row_t                row_mem [NUM_SETS];
  row_t                rd_row_r;
  row_t                fwd_row_r;
  logic                fwd_r;
  logic                out_valid_r;
  logic                out_blocked_r;
  logic [STATUS_W-1:0] out_status_r;

  logic                adv;
  logic [KEY_W-1:0]    key2;
  logic [SET_W-1:0]    idx2;
  row_t                row3;
  row_t                row_new;
  upd_ctl_t            ctl;
  logic                mem_wr;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv && !clr_busy_r;

  ebt_set_index #(.NUM_SETS(NUM_SETS)) u_set_index (
    .clk   (clk),
    .en    (adv),
    .key_i (key1_r),
    .key_o (key2),
    .idx_o (idx2)
  );

  assign row3 = fwd_r ? fwd_row_r : rd_row_r;

  ebt_way_update #(.WAYS(WAYS)) u_way_update (
    .action_i (act3_r),
    .key_i    (key3_r),
    .dur_i    (dur3_r),
    .now_i    (now_r),
    .row_i    (row3),
    .row_o    (row_new),
    .ctl_o    (ctl)
  );

  assign mem_wr = v3_r && adv && ctl.wr_en;

  // set memory
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      row_mem[clr_idx_r] <= '0;
    end else if (mem_wr) begin
      row_mem[idx3_r] <= row_new;
    end
    if (adv) begin
      rd_row_r <= row_mem[idx2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_idx_r   <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
      now_r       <= '0;
    end else begin
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + SET_W'(1);
        if (clr_idx_r == CLR_LAST) clr_busy_r <= 1'b0;
      end
      if (adv) begin
        v1_r        <= in_ch.valid && in_ch.ready;
        v2_r        <= v1_r;
        v3_r        <= v2_r;
        out_valid_r <= v3_r;
        // row written now is what the read made at the same edge misses
        fwd_r       <= mem_wr && (idx3_r == idx2);
        if (v3_r && act3_r == ACT_TICK) now_r <= now_r + TIME_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      act1_r        <= in_ch.action;
      key1_r        <= in_ch.key;
      dur1_r        <= in_ch.duration_ms;
      act2_r        <= act1_r;
      dur2_r        <= dur1_r;
      act3_r        <= act2_r;
      key3_r        <= key2;
      dur3_r        <= dur2_r;
      idx3_r        <= idx2;
      fwd_row_r     <= row_new;
      out_blocked_r <= ctl.blocked;
      out_status_r  <= ctl.status;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.blocked = out_blocked_r;
  assign out_ch.status  = out_status_r;

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ch.ready)
    else $error("request accepted during clearing pass");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r && clr_idx_r == CLR_LAST |=> !clr_busy_r)
    else $error("clearing pass did not end after last set");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v1_r)
    else $error("accepted word missing from input stage");

  a_leave_to_output: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && adv |=> out_valid_r)
    else $error("update stage word lost before output");

  a_blocked_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_blocked_r |-> out_status_r == ST_OK)
    else $error("blocked result carries error status");

endmodule

>>> dv/ebt_checker.sv
`timescale 1ns / 1ps
// checker for the expiring block table: watches both channels, predicts each result word
// from its own copy of the table and compares in order; depends on ebt_pkg, ebt_in_if, ebt_out_if

module ebt_checker import ebt_pkg::*; #(
  parameter int NUM_SETS = NUM_SETS_DEF,
  parameter int WAYS     = WAYS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ebt_in_if    in_mon,
  ebt_out_if   out_mon,
  output int   errors,
  output int   pending,
  output int   n_blocked,
  output int   n_full,
  output int   n_missing
);

  localparam int SLOTS = NUM_SETS * WAYS;

  typedef struct packed {
    logic                blocked;
    logic [STATUS_W-1:0] status;
  } outcome_t;

  logic              slot_valid  [SLOTS];
  logic [KEY_W-1:0]  slot_key    [SLOTS];
  logic [TIME_W-1:0] slot_expiry [SLOTS];
  logic [TIME_W-1:0] clock_ms;
  outcome_t          outcome_fifo [$];
  outcome_t          want;

  initial begin
    errors    = 0;
    n_blocked = 0;
    n_full    = 0;
    n_missing = 0;
    pending   = 0;
  end

  function automatic int find_slot(input int base, input logic [KEY_W-1:0] k);
    for (int w = 0; w < WAYS; w++) begin
      if (slot_valid[base + w] && slot_key[base + w] == k) return base + w;
    end
    return -1;
  endfunction

  function automatic outcome_t table_outcome(input logic [ACTION_W-1:0] act,
                                             input logic [KEY_W-1:0] k,
                                             input logic [TIME_W-1:0] dur);
    outcome_t o;
    int       base;
    int       hit;
    o.blocked = 1'b0;
    o.status  = ST_OK;
    base = int'(k % KEY_W'(NUM_SETS)) * WAYS;
    case (act)
      ACT_TICK: begin
        clock_ms = clock_ms + TIME_W'(1);
      end
      ACT_SET: begin
        hit = find_slot(base, k);
        if (hit < 0) begin
          // lowest free way
          for (int w = 0; w < WAYS; w++) begin
            if (!slot_valid[base + w]) begin
              hit = base + w;
              break;
            end
          end
        end
        if (hit < 0) begin
          o.status = ST_SET_FULL;
        end else begin
          slot_valid[hit]  = 1'b1;
          slot_key[hit]    = k;
          slot_expiry[hit] = dur + clock_ms;
        end
      end
      ACT_REMOVE: begin
        hit = find_slot(base, k);
        if (hit < 0) o.status = ST_NOT_FOUND;
        else slot_valid[hit] = 1'b0;
      end
      default: begin
        hit = find_slot(base, k);
        if (hit >= 0) begin
          if (clock_ms < slot_expiry[hit]) o.blocked = 1'b1;
          else slot_valid[hit] = 1'b0;
        end
      end
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
      clock_ms = '0;
      outcome_fifo.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (outcome_fifo.size() == 0) begin
          errors++;
          if (errors <= 20)
            $display("%0t: unexpected result word, expected none, got blocked=%0d status=%0d",
                     $time, out_mon.blocked, out_mon.status);
        end else begin
          want = outcome_fifo.pop_front();
          if (out_mon.blocked !== want.blocked) begin
            errors++;
            if (errors <= 20)
              $display("%0t: blocked mismatch, expected %0d, got %0d",
                       $time, want.blocked, out_mon.blocked);
          end
          if (out_mon.status !== want.status) begin
            errors++;
            if (errors <= 20)
              $display("%0t: status mismatch, expected %0d, got %0d",
                       $time, want.status, out_mon.status);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        want = table_outcome(in_mon.action, in_mon.key, in_mon.duration_ms);
        outcome_fifo.push_back(want);
        if (want.blocked) n_blocked++;
        if (want.status == ST_SET_FULL) n_full++;
        if (want.status == ST_NOT_FOUND) n_missing++;
      end
    end
    pending <= outcome_fifo.size();
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// top of the expiring block table testbench: clock, reset, request stimulus and result stalls;
// depends on ebt_pkg, ebt_in_if, ebt_out_if, expiring_block_table and ebt_checker

module testbench;
  import ebt_pkg::*;

  localparam int N_ITEMS        = 950;
  localparam int LIMIT          = 400000;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int POOL           = 24;

  logic clk;
  logic rst_n;
  int   cycles = 0;
  int   n_errors;
  int   n_pending;
  int   n_blocked;
  int   n_full;
  int   n_missing;
  int   n_sent = 0;
  int   n_by_act [4];
  logic quiet;
  int   squeeze_req;

  logic [KEY_W-1:0] key_pool [POOL];

  ebt_in_if  in_ch ();
  ebt_out_if out_ch ();

  expiring_block_table u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ebt_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .errors    (n_errors),
    .pending   (n_pending),
    .n_blocked (n_blocked),
    .n_full    (n_full),
    .n_missing (n_missing)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(15, 50);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, POOL - 1)];
    return $urandom();
  endfunction

  function automatic logic [TIME_W-1:0] pick_duration();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return '0;
    if (r < 12) return $urandom_range(1, 12);
    if (r < 16) return $urandom_range(13, 200);
    if (r < 18) return $urandom();
    // expiry sum wraps past zero
    if (r < 19) return 32'hFFFF_FFFF - $urandom_range(0, 5);
    return 32'hFFFF_FFFF;
  endfunction

  task automatic send_word(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] k,
                           input logic [TIME_W-1:0] dur);
    int gap;
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.key         <= k;
    in_ch.duration_ms <= dur;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
    n_by_act[act]++;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side stalls
  initial begin
    int r;
    int squeeze_seen;
    squeeze_seen = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (squeeze_req != squeeze_seen) begin
        squeeze_seen = squeeze_req;
        out_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end else if (quiet) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ch.ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_ch.ready <= 1'b0;
          r = $urandom_range(0, 99);
          if (r < 70) repeat ($urandom_range(1, 3)) @(posedge clk);
          else if (r < 95) repeat ($urandom_range(4, 12)) @(posedge clk);
          else repeat ($urandom_range(20, 60)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    logic [KEY_W-1:0]  k;
    logic [TIME_W-1:0] d;
    logic [KEY_W-1:0]  tmp;
    int                r;
    int                next_phase;
    bit                squeezed;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= ACT_TICK;
    in_ch.key         <= '0;
    in_ch.duration_ms <= '0;
    quiet             <= 1'b0;
    squeeze_req       <= 0;
    for (int i = 0; i < 4; i++) n_by_act[i] = 0;
    // six keys in each of four hot sets, so sets overflow
    for (int i = 0; i < POOL; i++) begin
      tmp = $urandom();
      case (i % 4)
        0: key_pool[i] = tmp - (tmp % KEY_W'(NUM_SETS_DEF));
        1: key_pool[i] = tmp - (tmp % KEY_W'(NUM_SETS_DEF)) + 1;
        2: key_pool[i] = tmp - (tmp % KEY_W'(NUM_SETS_DEF)) + 2;
        default: key_pool[i] = tmp - (tmp % KEY_W'(NUM_SETS_DEF)) + KEY_W'(NUM_SETS_DEF - 1);
      endcase
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: absent keys, zero duration, full set, overwrite, expiry and wrap
    send_word(ACT_QUERY,  32'h0000_0000, $urandom());
    send_word(ACT_REMOVE, 32'hFFFF_FFFF, $urandom());
    send_word(ACT_SET,    32'h0000_0000, 32'h0000_0000);
    send_word(ACT_QUERY,  32'h0000_0000, $urandom());
    send_word(ACT_QUERY,  32'h0000_0000, $urandom());
    send_word(ACT_SET,    32'h0000_0040, 32'hFFFF_FFFF);
    send_word(ACT_SET,    32'h0000_0080, 32'd3);
    send_word(ACT_SET,    32'h0000_00C0, 32'd3);
    send_word(ACT_SET,    32'h0000_0100, 32'd3);
    send_word(ACT_SET,    32'h0000_0140, 32'd5);
    send_word(ACT_SET,    32'h0000_0080, 32'd10);
    repeat (3) send_word(ACT_TICK, $urandom(), $urandom());
    send_word(ACT_QUERY,  32'h0000_0080, $urandom());
    send_word(ACT_QUERY,  32'h0000_0100, $urandom());
    send_word(ACT_SET,    32'h0000_0140, 32'd2);
    send_word(ACT_TICK,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(ACT_SET,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(ACT_QUERY,  32'hFFFF_FFFF, 32'h0000_0000);
    send_word(ACT_QUERY,  32'h0000_0040, $urandom());
    send_word(ACT_REMOVE, 32'h0000_0040, $urandom());
    send_word(ACT_REMOVE, 32'h0000_0040, $urandom());
    send_word(ACT_QUERY,  32'h0000_0140, $urandom());

    next_phase = n_sent;
    squeezed   = 1'b0;
    while (n_sent < N_ITEMS) begin
      if (n_sent >= next_phase) begin
        next_phase = n_sent + $urandom_range(30, 80);
        if (!squeezed && n_sent >= 400) begin
          // long result stall while requests keep coming back to back
          squeezed = 1'b1;
          squeeze_req <= squeeze_req + 1;
          quiet <= 1'b1;
        end else begin
          quiet <= ($urandom_range(0, 3) == 0);
        end
      end
      r = $urandom_range(0, 99);
      if (r < 15) begin
        // set, let some time pass, then ask about the same key
        k = pick_key();
        d = $urandom_range(0, 8);
        send_word(ACT_SET, k, d);
        repeat ($urandom_range(0, 10)) send_word(ACT_TICK, $urandom(), $urandom());
        send_word(ACT_QUERY, k, $urandom());
      end else if (r < 40) begin
        send_word(ACT_TICK, $urandom(), $urandom());
      end else if (r < 62) begin
        send_word(ACT_SET, pick_key(), pick_duration());
      end else if (r < 75) begin
        send_word(ACT_REMOVE, pick_key(), $urandom());
      end else begin
        send_word(ACT_QUERY, pick_key(), $urandom());
      end
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("testbench: %0d words (%0d tick, %0d set, %0d remove, %0d query), one long stall",
             n_sent, n_by_act[ACT_TICK], n_by_act[ACT_SET], n_by_act[ACT_REMOVE],
             n_by_act[ACT_QUERY]);
    $display("testbench: %0d blocked answers, %0d full-set refusals, %0d missing-key removes",
             n_blocked, n_full, n_missing);
    if (n_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/ebt_pkg.sv
hw/rtl/ebt_in_if.sv
hw/rtl/ebt_out_if.sv
hw/rtl/ebt_set_index.sv
hw/rtl/ebt_way_update.sv
hw/rtl/expiring_block_table.sv
dv/ebt_checker.sv
dv/testbench.sv
